// File: rtl/mupc_pkg.sv
`timescale 1ns / 1ps

package mupc_pkg;

    localparam int NUM_UNITS = 8;
    localparam int NUM_PINS  = 64;

    localparam int UIDX_W   = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
    localparam int LVL_W    = 64;
    localparam int PIN_W    = 6;
    localparam int UPIN_W   = 7;
    localparam int CNT_W    = 15;
    localparam int TOTAL_W  = 64;
    localparam int UNIT_W   = 3;
    localparam int STATUS_W = 2;

    localparam logic [CNT_W:0]    COUNT_LIMIT = 16'h7fff;
    localparam logic [UPIN_W-1:0] UNBOUND     = 7'h40;
    localparam logic [LVL_W-1:0]  PIN_MASK    = {LVL_W{1'b1}} >> (LVL_W - NUM_PINS);

    typedef enum logic [2:0] {
        ACT_SAMPLE  = 3'd0,
        ACT_CLAIM   = 3'd1,
        ACT_START   = 3'd2,
        ACT_STOP    = 3'd3,
        ACT_READ    = 3'd4,
        ACT_RELEASE = 3'd5
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_FREE   = 2'd1,
        ST_NOT_BOUND = 2'd2,
        ST_OUT_MODE  = 2'd3
    } status_t;

    localparam logic [1:0] POL_FALL = 2'd0;
    localparam logic [1:0] POL_RISE = 2'd1;
    localparam logic [1:0] POL_BOTH = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic look;
        logic apply;
    } dp_cmd_t;

    function automatic logic [UNIT_W-1:0] to_unit(input logic [UIDX_W-1:0] idx);
        logic [15:0] wide;
        wide = 16'(idx);
        return wide[UNIT_W-1:0];
    endfunction

endpackage

// File: rtl/mupc_item_if.sv
`timescale 1ns / 1ps

interface mupc_item_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [5:0]  pin;
    logic        input_mode;
    logic [1:0]  polarity;
    logic        clear_after_read;
    logic [63:0] pin_levels;

    modport source (
        output valid, action, pin, input_mode, polarity, clear_after_read, pin_levels,
        input  ready
    );
    modport sink (
        input  valid, action, pin, input_mode, polarity, clear_after_read, pin_levels,
        output ready
    );
endinterface

// File: rtl/mupc_result_if.sv
`timescale 1ns / 1ps

interface mupc_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [2:0]  unit;
    logic [63:0] total_count;

    modport source (
        output valid, status, unit, total_count,
        input  ready
    );
    modport sink (
        input  valid, status, unit, total_count,
        output ready
    );
endinterface

// File: rtl/multi_unit_edge_pulse_counter.sv
`timescale 1ns / 1ps
// Channel  Dir  Fields
// item     in   action, pin, input_mode, polarity, clear_after_read, pin_levels
// result   out  status, unit, total_count
//
// Each transaction passes through capture, unit lookup, apply and result;
// the sequencer holds one transaction at a time.
// rst_n is asynchronous: all units unbound, stopped, counts and overflow sums zero.
// A stalled result holds item.ready low until it is taken.

module multi_unit_edge_pulse_counter (
    input logic          clk,
    input logic          rst_n,
    mupc_item_if.sink    item,
    mupc_result_if.source result
);

    mupc_pkg::dp_cmd_t cmd;

    mupc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_ready   (item.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .cmd          (cmd)
    );

    mupc_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .action           (item.action),
        .pin              (item.pin),
        .input_mode       (item.input_mode),
        .polarity         (item.polarity),
        .clear_after_read (item.clear_after_read),
        .pin_levels       (item.pin_levels),
        .status           (result.status),
        .unit             (result.unit),
        .total_count      (result.total_count)
    );

endmodule

// File: rtl/mupc_ctrl.sv
`timescale 1ns / 1ps

module mupc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    output logic              result_valid,
    input  logic              result_ready,
    output mupc_pkg::dp_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_APPLY,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;
    logic   out_valid_reg;
    logic   accept;

    assign accept       = item_valid && in_ready_reg;
    assign item_ready   = in_ready_reg;
    assign result_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept) state_next = S_LOOK;
            S_LOOK:  state_next = S_APPLY;
            S_APPLY: state_next = S_OUT;
            S_OUT:   if (result_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.load  = accept;
        cmd.look  = (state_reg == S_LOOK);
        cmd.apply = (state_reg == S_APPLY);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_ready_reg  <= (state_next == S_IDLE);
            out_valid_reg <= (state_next == S_OUT);
        end
    end

    a_ready_valid_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready_reg && out_valid_reg))
        else $error("ready and result valid high together");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready_reg)
        else $error("second transaction taken while one in flight");

    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(accept, 3))
        else $error("result raised without a transaction three cycles before");

endmodule

// File: rtl/mupc_dp.sv
`timescale 1ns / 1ps

module mupc_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  mupc_pkg::dp_cmd_t                cmd,
    input  logic [2:0]                       action,
    input  logic [mupc_pkg::PIN_W-1:0]       pin,
    input  logic                             input_mode,
    input  logic [1:0]                       polarity,
    input  logic                             clear_after_read,
    input  logic [mupc_pkg::LVL_W-1:0]       pin_levels,
    output logic [mupc_pkg::STATUS_W-1:0]    status,
    output logic [mupc_pkg::UNIT_W-1:0]      unit,
    output logic [mupc_pkg::TOTAL_W-1:0]     total_count
);

    localparam int NU = mupc_pkg::NUM_UNITS;
    localparam int UW = mupc_pkg::UIDX_W;

    // captured transaction
    mupc_pkg::action_t               act_reg;
    logic [mupc_pkg::PIN_W-1:0]      pin_reg;
    logic                            mode_reg;
    logic [1:0]                      pol_reg;
    logic                            clr_reg;
    logic [mupc_pkg::LVL_W-1:0]      lvl_reg;

    // per-unit state
    logic [mupc_pkg::UPIN_W-1:0]     unit_pin_reg  [NU];
    logic [mupc_pkg::CNT_W-1:0]      count_reg     [NU];
    logic [mupc_pkg::TOTAL_W-1:0]    ovf_reg       [NU];
    logic [NU-1:0]                   running_reg;
    logic [NU-1:0]                   rise_en_reg;
    logic [NU-1:0]                   fall_en_reg;
    logic [mupc_pkg::LVL_W-1:0]      prev_reg;

    // lookup results
    logic [UW-1:0] look_idx_reg, look_idx_next;
    logic          look_hit_reg, look_hit_next;
    logic [UW-1:0] free_idx_reg, free_idx_next;
    logic          free_hit_reg, free_hit_next;

    // result
    logic [mupc_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [mupc_pkg::UNIT_W-1:0]   unit_reg, unit_next;
    logic [mupc_pkg::TOTAL_W-1:0]  total_reg, total_next;

    logic [mupc_pkg::LVL_W-1:0] cur_lvl;
    logic [mupc_pkg::LVL_W-1:0] rise_lvl;
    logic [mupc_pkg::LVL_W-1:0] fall_lvl;
    logic [NU-1:0]              hit;
    logic [NU-1:0]              cnt_high;

    assign cur_lvl  = lvl_reg & mupc_pkg::PIN_MASK;
    assign rise_lvl = cur_lvl & ~prev_reg;
    assign fall_lvl = ~cur_lvl & prev_reg;

    always_comb
    begin
        for (int u = 0; u < NU; u++)
        begin
            hit[u] = running_reg[u] && !unit_pin_reg[u][mupc_pkg::UPIN_W-1]
                  && ((rise_en_reg[u] && rise_lvl[unit_pin_reg[u][mupc_pkg::PIN_W-1:0]])
                   || (fall_en_reg[u] && fall_lvl[unit_pin_reg[u][mupc_pkg::PIN_W-1:0]]));
            cnt_high[u] = ({1'b0, count_reg[u]} >= mupc_pkg::COUNT_LIMIT);
        end
    end

    // lowest matching unit wins: scan from the top down
    always_comb
    begin
        look_idx_next = '0;
        look_hit_next = 1'b0;
        free_idx_next = '0;
        free_hit_next = 1'b0;
        for (int u = NU - 1; u >= 0; u--)
        begin
            if (!unit_pin_reg[u][mupc_pkg::UPIN_W-1]
                && unit_pin_reg[u][mupc_pkg::PIN_W-1:0] == pin_reg)
            begin
                look_idx_next = UW'(u);
                look_hit_next = 1'b1;
            end
            if (unit_pin_reg[u][mupc_pkg::UPIN_W-1])
            begin
                free_idx_next = UW'(u);
                free_hit_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        status_next = mupc_pkg::ST_OK;
        unit_next   = '0;
        total_next  = '0;
        unique case (act_reg)
            mupc_pkg::ACT_SAMPLE: ;
            mupc_pkg::ACT_CLAIM:
            begin
                if (!mode_reg)
                    status_next = mupc_pkg::ST_OUT_MODE;
                else if (!free_hit_reg)
                    status_next = mupc_pkg::ST_NO_FREE;
                else
                    unit_next = mupc_pkg::to_unit(free_idx_reg);
            end
            mupc_pkg::ACT_START, mupc_pkg::ACT_STOP, mupc_pkg::ACT_READ,
            mupc_pkg::ACT_RELEASE:
            begin
                if (!look_hit_reg)
                    status_next = mupc_pkg::ST_NOT_BOUND;
                else
                begin
                    unit_next = mupc_pkg::to_unit(look_idx_reg);
                    if (act_reg == mupc_pkg::ACT_READ)
                        total_next = ovf_reg[look_idx_reg]
                                   + mupc_pkg::TOTAL_W'(count_reg[look_idx_reg]);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg  <= mupc_pkg::action_t'(action);
            pin_reg  <= pin;
            mode_reg <= input_mode;
            pol_reg  <= polarity;
            clr_reg  <= clear_after_read;
            lvl_reg  <= pin_levels;
        end
        if (cmd.look)
        begin
            look_idx_reg <= look_idx_next;
            look_hit_reg <= look_hit_next;
            free_idx_reg <= free_idx_next;
            free_hit_reg <= free_hit_next;
        end
        if (cmd.apply)
        begin
            status_reg <= status_next;
            unit_reg   <= unit_next;
            total_reg  <= total_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int u = 0; u < NU; u++)
            begin
                unit_pin_reg[u] <= mupc_pkg::UNBOUND;
                count_reg[u]    <= '0;
                ovf_reg[u]      <= '0;
            end
            running_reg <= '0;
            rise_en_reg <= '0;
            fall_en_reg <= '0;
            prev_reg    <= '0;
        end
        else if (cmd.apply)
        begin
            if (act_reg == mupc_pkg::ACT_SAMPLE)
                prev_reg <= cur_lvl;
            for (int u = 0; u < NU; u++)
            begin
                unique case (act_reg)
                    mupc_pkg::ACT_SAMPLE:
                    begin
                        if (hit[u])
                        begin
                            if (({1'b0, count_reg[u]} + 1'b1) >= mupc_pkg::COUNT_LIMIT)
                            begin
                                count_reg[u] <= '0;
                                ovf_reg[u]   <= ovf_reg[u]
                                              + mupc_pkg::TOTAL_W'(mupc_pkg::COUNT_LIMIT);
                            end
                            else
                                count_reg[u] <= count_reg[u] + 1'b1;
                        end
                    end
                    mupc_pkg::ACT_CLAIM:
                    begin
                        if (mode_reg && free_hit_reg && free_idx_reg == UW'(u))
                            unit_pin_reg[u] <= {1'b0, pin_reg};
                    end
                    mupc_pkg::ACT_START:
                    begin
                        if (look_hit_reg && look_idx_reg == UW'(u))
                        begin
                            rise_en_reg[u] <= (pol_reg == mupc_pkg::POL_RISE)
                                           || (pol_reg == mupc_pkg::POL_BOTH);
                            fall_en_reg[u] <= (pol_reg == mupc_pkg::POL_FALL)
                                           || (pol_reg == mupc_pkg::POL_BOTH);
                            count_reg[u]   <= '0;
                            ovf_reg[u]     <= '0;
                            running_reg[u] <= 1'b1;
                        end
                    end
                    mupc_pkg::ACT_STOP:
                    begin
                        if (look_hit_reg && look_idx_reg == UW'(u))
                            running_reg[u] <= 1'b0;
                    end
                    mupc_pkg::ACT_READ:
                    begin
                        if (look_hit_reg && look_idx_reg == UW'(u) && clr_reg)
                        begin
                            count_reg[u] <= '0;
                            ovf_reg[u]   <= '0;
                        end
                    end
                    mupc_pkg::ACT_RELEASE:
                    begin
                        if (look_hit_reg && look_idx_reg == UW'(u))
                        begin
                            running_reg[u]  <= 1'b0;
                            rise_en_reg[u]  <= 1'b0;
                            fall_en_reg[u]  <= 1'b0;
                            count_reg[u]    <= '0;
                            unit_pin_reg[u] <= mupc_pkg::UNBOUND;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    assign status      = status_reg;
    assign unit        = unit_reg;
    assign total_count = total_reg;

    a_count_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_high == '0)
        else $error("unit count reached the wrap limit");

    a_prev_tracks_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.apply && act_reg == mupc_pkg::ACT_SAMPLE) |=> prev_reg == $past(cur_lvl))
        else $error("previous levels not updated by sample");

    a_fail_zero_unit: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.apply && status_next != mupc_pkg::ST_OK)
            |=> (unit_reg == '0 && total_reg == '0))
        else $error("failed transaction carries a unit or total");

endmodule

// File: tb/multi_unit_edge_pulse_counter_test.sv
`timescale 1ns / 1ps

module multi_unit_edge_pulse_counter_test;
    import mupc_pkg::*;

    localparam int          CYCLE_LIMIT = 1_000_000;
    localparam int          DRAIN_WAIT  = 20;
    localparam int          RANDOM_ITEMS = 1560;
    localparam int          COUNT_SAMPLES = 48;
    localparam logic [2:0]  ACT_RSVD6   = 3'd6;
    localparam logic [2:0]  ACT_RSVD7   = 3'd7;
    localparam logic [1:0]  POL_NONE    = 2'd3;

    typedef struct {
        logic [2:0]          action;
        logic [PIN_W-1:0]    pin;
        logic                input_mode;
        logic [1:0]          polarity;
        logic                clear_after_read;
        logic [LVL_W-1:0]    pin_levels;
    } counter_cmd_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [UNIT_W-1:0]   unit;
        logic [TOTAL_W-1:0]  total;
    } counter_reply_t;

    class edge_count_scoreboard;
        logic [UPIN_W-1:0]  bound_pin [NUM_UNITS];
        logic [CNT_W-1:0]   edge_count [NUM_UNITS];
        logic [TOTAL_W-1:0] overflow_sum [NUM_UNITS];
        bit                 running [NUM_UNITS];
        bit                 on_rise [NUM_UNITS];
        bit                 on_fall [NUM_UNITS];
        logic [LVL_W-1:0]   last_levels;
        counter_reply_t     expected_replies [$];
        int                 errors;
        int                 checked;
        int                 samples;
        int                 wraps;

        function new();
            for (int u = 0; u < NUM_UNITS; u++)
            begin
                bound_pin[u]    = UNBOUND;
                edge_count[u]   = '0;
                overflow_sum[u] = '0;
                running[u]      = 1'b0;
                on_rise[u]      = 1'b0;
                on_fall[u]      = 1'b0;
            end
            last_levels = '0;
            errors  = 0;
            checked = 0;
            samples = 0;
            wraps   = 0;
        endfunction

        function void note_item(counter_cmd_t c);
            counter_reply_t   r;
            int               hit_unit;
            logic [LVL_W-1:0] cur;
            logic [LVL_W-1:0] rise;
            logic [LVL_W-1:0] fall;
            logic [PIN_W-1:0] p;
            logic [CNT_W:0]   nxt;
            r.status = ST_OK;
            r.unit   = '0;
            r.total  = '0;
            hit_unit = -1;
            if (c.action == ACT_SAMPLE)
            begin
                samples++;
                cur  = c.pin_levels & PIN_MASK;
                rise = cur & ~last_levels;
                fall = ~cur & last_levels;
                for (int u = 0; u < NUM_UNITS; u++)
                begin
                    if (running[u] && !bound_pin[u][PIN_W])
                    begin
                        p = bound_pin[u][PIN_W-1:0];
                        if ((on_rise[u] && rise[p]) || (on_fall[u] && fall[p]))
                        begin
                            nxt = {1'b0, edge_count[u]} + 1'b1;
                            if (nxt >= COUNT_LIMIT)
                            begin
                                edge_count[u]   = '0;
                                overflow_sum[u] = overflow_sum[u] + TOTAL_W'(COUNT_LIMIT);
                                wraps++;
                            end
                            else
                                edge_count[u] = nxt[CNT_W-1:0];
                        end
                    end
                end
                last_levels = cur;
            end
            else if (c.action == ACT_CLAIM)
            begin
                if (!c.input_mode)
                    r.status = ST_OUT_MODE;
                else
                begin
                    for (int u = NUM_UNITS - 1; u >= 0; u--)
                        if (bound_pin[u][PIN_W])
                            hit_unit = u;
                    if (hit_unit < 0)
                        r.status = ST_NO_FREE;
                    else
                    begin
                        bound_pin[hit_unit] = {1'b0, c.pin};
                        r.unit = UNIT_W'(hit_unit);
                    end
                end
            end
            else if (c.action >= ACT_START && c.action <= ACT_RELEASE)
            begin
                for (int u = NUM_UNITS - 1; u >= 0; u--)
                    if (!bound_pin[u][PIN_W] && bound_pin[u][PIN_W-1:0] == c.pin)
                        hit_unit = u;
                if (hit_unit < 0)
                    r.status = ST_NOT_BOUND;
                else
                begin
                    r.unit = UNIT_W'(hit_unit);
                    case (c.action)
                        ACT_START:
                        begin
                            on_rise[hit_unit] = (c.polarity == POL_RISE
                                                 || c.polarity == POL_BOTH);
                            on_fall[hit_unit] = (c.polarity == POL_FALL
                                                 || c.polarity == POL_BOTH);
                            edge_count[hit_unit]   = '0;
                            overflow_sum[hit_unit] = '0;
                            running[hit_unit]      = 1'b1;
                        end
                        ACT_STOP:
                            running[hit_unit] = 1'b0;
                        ACT_READ:
                        begin
                            r.total = overflow_sum[hit_unit]
                                      + TOTAL_W'(edge_count[hit_unit]);
                            if (c.clear_after_read)
                            begin
                                edge_count[hit_unit]   = '0;
                                overflow_sum[hit_unit] = '0;
                            end
                        end
                        default:
                        begin
                            running[hit_unit]    = 1'b0;
                            on_rise[hit_unit]    = 1'b0;
                            on_fall[hit_unit]    = 1'b0;
                            edge_count[hit_unit] = '0;
                            bound_pin[hit_unit]  = UNBOUND;
                        end
                    endcase
                end
            end
            expected_replies.push_back(r);
        endfunction

        function void check_result(logic [STATUS_W-1:0] status, logic [UNIT_W-1:0] unit,
                                   logic [TOTAL_W-1:0] total);
            counter_reply_t e;
            checked++;
            if (expected_replies.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: result with nothing pending: status %0d unit %0d total %h",
                             $realtime, status, unit, total);
                return;
            end
            e = expected_replies.pop_front();
            if (status !== e.status || unit !== e.unit || total !== e.total)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: mismatch: expected status %0d unit %0d total %h, got %0d %0d %h",
                             $realtime, e.status, e.unit, e.total, status, unit, total);
            end
        endfunction

        function int pending();
            return expected_replies.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    bit                   steady;
    int                   sent;
    int                   cycle_count;
    logic [PIN_W-1:0]     pin_pool [10];
    edge_count_scoreboard sb;

    mupc_item_if   item_ch ();
    mupc_result_if result_ch ();

    multi_unit_edge_pulse_counter i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    initial
        clk = 1'b0;
    always #6 clk = ~clk;

    // arg carries the field that the action uses; fields other than action, pin and that one are random
    task automatic issue(input logic [2:0] act, input logic [PIN_W-1:0] p,
                         input logic [LVL_W-1:0] arg);
        counter_cmd_t c;
        c.action           = act;
        c.pin              = p;
        c.input_mode       = 1'($urandom_range(0, 1));
        c.polarity         = 2'($urandom_range(0, 3));
        c.clear_after_read = 1'($urandom_range(0, 1));
        c.pin_levels       = {$urandom, $urandom};
        case (act)
            ACT_SAMPLE: c.pin_levels       = arg;
            ACT_CLAIM:  c.input_mode       = arg[0];
            ACT_START:  c.polarity         = arg[1:0];
            ACT_READ:   c.clear_after_read = arg[0];
            default:    ;
        endcase
        while (!steady && $urandom_range(0, 99) < 10)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid            <= 1'b1;
        item_ch.action           <= c.action;
        item_ch.pin              <= c.pin;
        item_ch.input_mode       <= c.input_mode;
        item_ch.polarity         <= c.polarity;
        item_ch.clear_after_read <= c.clear_after_read;
        item_ch.pin_levels       <= c.pin_levels;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        sb.note_item(c);
        sent++;
    endtask

    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
                sb.check_result(result_ch.status, result_ch.unit, result_ch.total_count);
            result_ch.ready <= steady || ($urandom_range(0, 99) >= 10);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int                r;
        logic [PIN_W-1:0]  p;
        logic [LVL_W-1:0]  arg;
        logic [2:0]        act;
        sb     = new();
        sent   = 0;
        steady = 1'b0;
        rst_n                    <= 1'b0;
        item_ch.valid            <= 1'b0;
        item_ch.action           <= ACT_SAMPLE;
        item_ch.pin              <= '0;
        item_ch.input_mode       <= 1'b0;
        item_ch.polarity         <= POL_FALL;
        item_ch.clear_after_read <= 1'b0;
        item_ch.pin_levels       <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: binding rules, polarities, first-sample edge, stop/restart
        issue(ACT_READ, 6'd5, '0);
        issue(ACT_CLAIM, 6'd63, '0);
        issue(ACT_CLAIM, 6'd0, 64'd1);
        issue(ACT_CLAIM, 6'd63, 64'd1);
        issue(ACT_CLAIM, 6'd0, 64'd1);
        issue(ACT_START, 6'd0, 64'(POL_RISE));
        issue(ACT_START, 6'd63, 64'(POL_BOTH));
        issue(ACT_RSVD6, 6'd0, '0);
        issue(ACT_RSVD7, 6'd63, '1);
        issue(ACT_SAMPLE, 6'd0, '1);
        issue(ACT_SAMPLE, 6'd0, '0);
        issue(ACT_SAMPLE, 6'd0, '1);
        issue(ACT_READ, 6'd0, '0);
        issue(ACT_READ, 6'd63, 64'd1);
        issue(ACT_STOP, 6'd63, '0);
        issue(ACT_STOP, 6'd63, '0);
        issue(ACT_START, 6'd0, 64'(POL_NONE));
        issue(ACT_START, 6'd63, 64'(POL_FALL));
        issue(ACT_SAMPLE, 6'd0, '0);
        issue(ACT_READ, 6'd63, '0);
        for (int i = 10; i < 16; i++)
            issue(ACT_CLAIM, PIN_W'(i), 64'd1);
        issue(ACT_RELEASE, 6'd0, '0);
        issue(ACT_READ, 6'd0, 64'd1);

        // random: mostly a small pin pool so that lookups succeed
        pin_pool[0] = 6'd0;
        pin_pool[1] = 6'd63;
        for (int i = 2; i < 10; i++)
            pin_pool[i] = PIN_W'($urandom_range(0, 63));
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            steady = (n >= 700 && n < 1100);
            p = ($urandom_range(0, 99) < 85) ? pin_pool[$urandom_range(0, 9)]
                                             : PIN_W'($urandom_range(0, 63));
            r = $urandom_range(0, 99);
            if (r < 50)
            begin
                act = ACT_SAMPLE;
                r = $urandom_range(0, 9);
                arg = (r == 0) ? '0 : (r == 1) ? '1 : {$urandom, $urandom};
            end
            else if (r < 60)
            begin
                act = ACT_CLAIM;
                arg = LVL_W'($urandom_range(0, 9) != 0);
            end
            else if (r < 70)
            begin
                act = ACT_START;
                arg = LVL_W'($urandom_range(0, 3));
            end
            else
            begin
                act = (r < 76) ? ACT_STOP : (r < 88) ? ACT_READ : (r < 97) ? ACT_RELEASE
                      : (r < 98) ? ACT_RSVD6 : ACT_RSVD7;
                arg = LVL_W'($urandom_range(0, 1));
            end
            issue(act, p, arg);
        end
        steady = 1'b0;

        // free every unit, then count on three units with each edge selection
        for (int u = 0; u < NUM_UNITS; u++)
            while (!sb.bound_pin[u][PIN_W])
                issue(ACT_RELEASE, sb.bound_pin[u][PIN_W-1:0], '0);
        issue(ACT_CLAIM, 6'd9, 64'd1);
        issue(ACT_START, 6'd9, 64'(POL_BOTH));
        issue(ACT_CLAIM, 6'd50, 64'd1);
        issue(ACT_START, 6'd50, 64'(POL_RISE));
        issue(ACT_CLAIM, 6'd51, 64'd1);
        issue(ACT_START, 6'd51, 64'(POL_FALL));
        for (int n = 0; n < COUNT_SAMPLES; n++)
        begin
            issue(ACT_SAMPLE, PIN_W'($urandom_range(0, 63)), n[0] ? '1 : '0);
            if (n % 16 == 15)
                issue(ACT_READ, 6'd9, '0);
        end
        issue(ACT_READ, 6'd9, '0);
        issue(ACT_READ, 6'd50, '0);
        issue(ACT_RELEASE, 6'd9, '0);
        issue(ACT_CLAIM, 6'd9, 64'd1);
        issue(ACT_READ, 6'd9, 64'd1);
        issue(ACT_READ, 6'd9, '0);
        item_ch.valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Sent %0d transactions (%0d pin samples), checked %0d results.",
                 sent, sb.samples, sb.checked);
        $display("Counter wraps seen: %0d; mismatches: %0d.", sb.wraps, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: filelist.f
rtl/mupc_pkg.sv
rtl/mupc_item_if.sv
rtl/mupc_result_if.sv
rtl/mupc_ctrl.sv
rtl/mupc_dp.sv
rtl/multi_unit_edge_pulse_counter.sv
tb/multi_unit_edge_pulse_counter_test.sv
